// ===== design/hot_block_separation_tracker_macros.svh =====
// ----------------------------------------------------------------------------
// Hot block separation tracker - assertion macros
// Shared property wrappers for the checker; clk and rst_n are taken from scope.
// ----------------------------------------------------------------------------
`ifndef HOT_BLOCK_SEPARATION_TRACKER_MACROS_SVH
`define HOT_BLOCK_SEPARATION_TRACKER_MACROS_SVH

// same-cycle implication
`define HBST_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HBST_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/hbst_pkg.sv =====
// ----------------------------------------------------------------------------
// hbst_pkg
// Types and constants shared by the hot block separation tracker.
// ----------------------------------------------------------------------------
package hbst_pkg;

    localparam int NUM_BLOCKS_DEF  = 1024 * 1024;
    localparam int STAMP_BITS_DEF  = 48;

    localparam int ADDR_IN_W       = 20;
    localparam int CFG_W           = 32;
    localparam int TAG_W           = 32;
    localparam int DIST_W          = 48;
    localparam int SET_SIZE_W      = 21;
    localparam int CNT_W           = 32;
    localparam int SUM_W           = 48;

    localparam logic [CFG_W-1:0] GC_PERIOD_RST = 32'd1048576;
    localparam logic [CFG_W-1:0] HOT_THR_RST   = 32'd524288;

    // address reduction for depths below 2^20 that are not a power of two:
    // quotient estimate by reciprocal multiply, then one correction
    localparam int RECIP_SHIFT     = 40;
    localparam int RECIP_W         = 31;
    localparam int QUOT_W          = 11;

    typedef enum logic
    {
        CFG_GC_PERIOD     = 1'b0,
        CFG_HOT_THRESHOLD = 1'b1
    } cfg_index_t;

    typedef enum logic [2:0]
    {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_REM,
        S_READ,
        S_CALC,
        S_UPDATE
    } hbst_state_t;

    typedef struct packed
    {
        logic [DIST_W-1:0]     update_distance;
        logic                  first_write;
        logic                  is_hot;
        logic                  gc_done;
        logic [SET_SIZE_W-1:0] hot_set_size;
        logic [CNT_W-1:0]      hot_write_count;
        logic [SUM_W-1:0]      set_size_sum;
        logic [SUM_W-1:0]      hot_write_sum;
        logic [CNT_W-1:0]      collections;
    } hbst_result_t;

endpackage

// ===== design/hbst_if.sv =====
// ----------------------------------------------------------------------------
// hbst_if
// Valid/ready channels for block writes in and tracker results out.
// ----------------------------------------------------------------------------
interface hbst_item_if;
    import hbst_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [ADDR_IN_W-1:0] block_addr;

    modport source (output valid, output block_addr, input ready);
    modport sink   (input valid, input block_addr, output ready);
endinterface

interface hbst_result_if;
    import hbst_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [DIST_W-1:0]     update_distance;
    logic                  first_write;
    logic                  is_hot;
    logic                  gc_done;
    logic [SET_SIZE_W-1:0] hot_set_size;
    logic [CNT_W-1:0]      hot_write_count;
    logic [SUM_W-1:0]      set_size_sum;
    logic [SUM_W-1:0]      hot_write_sum;
    logic [CNT_W-1:0]      collections;

    modport source (output valid, output update_distance, output first_write,
                    output is_hot, output gc_done, output hot_set_size,
                    output hot_write_count, output set_size_sum,
                    output hot_write_sum, output collections, input ready);
    modport sink   (input valid, input update_distance, input first_write,
                    input is_hot, input gc_done, input hot_set_size,
                    input hot_write_count, input set_size_sum,
                    input hot_write_sum, input collections, output ready);
endinterface

// ===== design/hbst_table.sv =====
// ----------------------------------------------------------------------------
// hbst_table
// Per-block entry store: {epoch tag, last write stamp}, one write and one
// registered read per cycle.
// ----------------------------------------------------------------------------
module hbst_table #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10,
    parameter int DATA_W = 80
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== design/hbst_core.sv =====
// ----------------------------------------------------------------------------
// hbst_core
// Sequencer and counters: clears the table after reset, then per block write
// reads the entry, works out distance and collection, and writes it back.
// ----------------------------------------------------------------------------
module hbst_core #(
    parameter int NUM_BLOCKS = 1024 * 1024,
    parameter int STAMP_BITS = 48,
    parameter int ADDR_BITS  = 20
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_ready,
    input  logic [hbst_pkg::ADDR_IN_W-1:0]    block_addr,
    input  logic                              cfg_wr_en,
    input  hbst_pkg::cfg_index_t              cfg_index,
    input  logic [hbst_pkg::CFG_W-1:0]        cfg_data,
    input  logic                              slot_free,
    output logic                              res_load,
    output hbst_pkg::hbst_result_t            res,
    output logic                              rd_en,
    output logic [ADDR_BITS-1:0]              rd_addr,
    input  logic [hbst_pkg::TAG_W+STAMP_BITS-1:0] rd_data,
    output logic                              wr_en,
    output logic [ADDR_BITS-1:0]              wr_addr,
    output logic [hbst_pkg::TAG_W+STAMP_BITS-1:0] wr_data
);
    import hbst_pkg::*;

    localparam int ENTRY_W = TAG_W + STAMP_BITS;
    localparam int PROD_W  = ADDR_IN_W + RECIP_W;
    localparam bit NEED_MOD = (NUM_BLOCKS < (2 ** ADDR_IN_W)) &&
                              ((NUM_BLOCKS & (NUM_BLOCKS - 1)) != 0);
    // floor(2^40 / depth): the quotient estimate is low by at most one
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'((64'(1) << RECIP_SHIFT) / 64'(NUM_BLOCKS));
    localparam logic [ADDR_IN_W:0] DEPTH_X = (ADDR_IN_W+1)'(NUM_BLOCKS);
    localparam logic [ADDR_BITS-1:0] CLR_LAST = ADDR_BITS'(NUM_BLOCKS - 1);

    hbst_state_t state_reg, state_next;

    logic [ADDR_BITS-1:0]  clr_addr_reg;
    logic [ADDR_BITS-1:0]  addr_reg;
    logic [ADDR_IN_W-1:0]  mod_val_reg;
    logic [QUOT_W-1:0]     quot_reg;
    logic [ADDR_IN_W:0]    rem_reg;

    logic [STAMP_BITS-1:0] wc_reg;
    logic [CNT_W-1:0]      phase_reg;
    logic [TAG_W-1:0]      mark_reg;
    logic [SET_SIZE_W-1:0] set_size_reg;
    logic [CNT_W-1:0]      hot_writes_reg;
    logic [SUM_W-1:0]      size_sum_reg;
    logic [SUM_W-1:0]      writes_sum_reg;
    logic [CNT_W-1:0]      coll_reg;
    logic [CFG_W-1:0]      gc_period_reg;
    logic [CFG_W-1:0]      hot_thr_reg;

    logic [STAMP_BITS-1:0] dist_reg;
    logic                  first_reg;
    logic                  gc_reg;

    logic [ADDR_IN_W+ADDR_BITS-1:0] addr_ext;
    logic [ADDR_BITS-1:0]  in_addr;
    logic                  accept;
    logic                  clr_last;
    logic [PROD_W-1:0]     recip_prod;
    logic [ADDR_IN_W:0]    rem_fix;
    logic [ADDR_BITS-1:0]  mod_addr;
    logic [STAMP_BITS-1:0] stamp;
    logic [TAG_W-1:0]      tag;
    logic                  in_set;
    logic                  hot;
    logic [TAG_W-1:0]      tag_new;
    logic [SET_SIZE_W-1:0] set_size_upd;
    logic [CNT_W-1:0]      hot_writes_upd;
    logic [63:0]           dist_ext;

    assign addr_ext   = {ADDR_BITS'(0), block_addr};
    assign in_addr    = addr_ext[ADDR_BITS-1:0];
    assign accept     = item_valid && item_ready;
    assign clr_last   = (clr_addr_reg == CLR_LAST);
    assign recip_prod = PROD_W'(mod_val_reg) * PROD_W'(RECIP);
    assign rem_fix    = (rem_reg >= DEPTH_X) ? rem_reg - DEPTH_X : rem_reg;
    assign mod_addr   = ADDR_BITS'(rem_fix);
    assign stamp      = rd_data[STAMP_BITS-1:0];
    assign tag        = rd_data[ENTRY_W-1:STAMP_BITS];
    assign in_set     = (tag == mark_reg);
    assign hot        = (dist_reg != '0) && (64'(dist_reg) < 64'(hot_thr_reg));
    assign dist_ext   = 64'(dist_reg);

    // separation decision against the current epoch mark
    always_comb
    begin
        tag_new        = tag;
        set_size_upd   = set_size_reg;
        hot_writes_upd = hot_writes_reg;
        if (hot)
        begin
            hot_writes_upd = hot_writes_reg + 1'b1;
            if (!in_set)
            begin
                tag_new      = mark_reg;
                set_size_upd = set_size_reg + 1'b1;
            end
        end
        else if (in_set)
        begin
            tag_new      = '0;
            set_size_upd = set_size_reg - 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:  if (clr_last) state_next = S_IDLE;
            S_IDLE:   if (item_valid) state_next = NEED_MOD ? S_MOD : S_CALC;
            S_MOD:    state_next = S_REM;
            S_REM:    state_next = S_READ;
            S_READ:   state_next = S_CALC;
            S_CALC:   state_next = S_UPDATE;
            S_UPDATE: if (slot_free) state_next = S_IDLE;
            default:  state_next = S_CLEAR;
        endcase
    end

    always_comb
    begin
        item_ready = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = in_addr;
        wr_en      = 1'b0;
        wr_addr    = addr_reg;
        wr_data    = {tag_new, wc_reg};
        res_load   = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_addr_reg;
                wr_data = '0;
            end
            S_IDLE:
            begin
                item_ready = 1'b1;
                rd_en      = item_valid && !NEED_MOD;
            end
            S_READ:
            begin
                rd_en   = 1'b1;
                rd_addr = mod_addr;
            end
            S_UPDATE:
            begin
                wr_en    = slot_free;
                res_load = slot_free;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        res.update_distance = dist_ext[DIST_W-1:0];
        res.first_write     = first_reg;
        res.is_hot          = hot;
        res.gc_done         = gc_reg;
        res.hot_set_size    = set_size_upd;
        res.hot_write_count = hot_writes_upd;
        res.set_size_sum    = size_sum_reg;
        res.hot_write_sum   = writes_sum_reg;
        res.collections     = coll_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_addr_reg   <= '0;
            wc_reg         <= '0;
            phase_reg      <= '0;
            mark_reg       <= TAG_W'(1);
            set_size_reg   <= '0;
            hot_writes_reg <= '0;
            size_sum_reg   <= '0;
            writes_sum_reg <= '0;
            coll_reg       <= '0;
            gc_period_reg  <= GC_PERIOD_RST;
            hot_thr_reg    <= HOT_THR_RST;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_GC_PERIOD:     gc_period_reg <= cfg_data;
                    CFG_HOT_THRESHOLD: hot_thr_reg   <= cfg_data;
                    default:           hot_thr_reg   <= hot_thr_reg;
                endcase
            end

            if (state_reg == S_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end

            if (accept)
            begin
                wc_reg    <= wc_reg + 1'b1;
                phase_reg <= phase_reg + 1'b1;
            end

            // collection closes ahead of the separation decision
            if (state_reg == S_CALC && phase_reg >= gc_period_reg)
            begin
                phase_reg      <= '0;
                size_sum_reg   <= size_sum_reg + SUM_W'(set_size_reg);
                writes_sum_reg <= writes_sum_reg + SUM_W'(hot_writes_reg);
                coll_reg       <= coll_reg + 1'b1;
                set_size_reg   <= '0;
                hot_writes_reg <= '0;
                mark_reg       <= mark_reg + 1'b1;
            end

            if (res_load)
            begin
                set_size_reg   <= set_size_upd;
                hot_writes_reg <= hot_writes_upd;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            addr_reg    <= in_addr;
            mod_val_reg <= block_addr;
        end
        else if (state_reg == S_MOD)
        begin
            quot_reg <= recip_prod[RECIP_SHIFT +: QUOT_W];
        end
        else if (state_reg == S_REM)
        begin
            // remainder lands in [0, 2*depth), one subtract left
            rem_reg <= {1'b0, mod_val_reg} - (ADDR_IN_W+1)'(quot_reg) * DEPTH_X;
        end
        else if (state_reg == S_READ)
        begin
            addr_reg <= mod_addr;
        end

        if (state_reg == S_CALC)
        begin
            first_reg <= (stamp == '0);
            dist_reg  <= (stamp == '0) ? '0 : wc_reg - stamp;
            gc_reg    <= (phase_reg >= gc_period_reg);
        end
    end

endmodule

// ===== design/hot_block_separation_tracker.sv =====
// ----------------------------------------------------------------------------
// hot_block_separation_tracker
// Per-block update distance and hot-set tracking with periodic collections.
//
// Channels: item (sink) carries one block_addr per beat; result (source)
// carries one result beat per accepted item, in order. Configuration is a
// plain write port (cfg_wr_en, cfg_index, cfg_data), written while idle.
// The table entry is read at the accepting edge, distance and collection are
// worked out in the next cycle, then the entry is written back and the result
// register loaded once it is free. When NUM_BLOCKS is not a power of two and
// below 2^20, the address is first reduced by a reciprocal multiply (S_MOD)
// and one correction (S_REM), and the entry is read after that (S_READ)
// rather than at the accepting edge. The rate is set by the sequencer, which
// takes one item at a time through read, calculate and write-back.
// After reset the table is cleared one entry a cycle, every entry in turn;
// item.ready stays low meanwhile; configuration writes are taken as ever.
// A stalled result waits in the output register; the next item may still be
// accepted and held at write-back until the register frees up.
// ----------------------------------------------------------------------------
module hot_block_separation_tracker #(
    parameter int NUM_BLOCKS = hbst_pkg::NUM_BLOCKS_DEF,
    parameter int STAMP_BITS = hbst_pkg::STAMP_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    hbst_item_if.sink                  item,
    hbst_result_if.source              result,
    input  logic                       cfg_wr_en,
    input  hbst_pkg::cfg_index_t       cfg_index,
    input  logic [hbst_pkg::CFG_W-1:0] cfg_data
);
    import hbst_pkg::*;

    localparam int ADDR_BITS = $clog2(NUM_BLOCKS);
    localparam int ENTRY_W   = TAG_W + STAMP_BITS;

    logic                 slot_free;
    logic                 res_load;
    hbst_result_t         res;
    hbst_result_t         res_reg;
    logic                 out_valid_reg;
    logic                 rd_en;
    logic [ADDR_BITS-1:0] rd_addr;
    logic [ENTRY_W-1:0]   rd_data;
    logic                 wr_en;
    logic [ADDR_BITS-1:0] wr_addr;
    logic [ENTRY_W-1:0]   wr_data;

    hbst_core #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .STAMP_BITS (STAMP_BITS),
        .ADDR_BITS  (ADDR_BITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_ready (item.ready),
        .block_addr (item.block_addr),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .slot_free  (slot_free),
        .res_load   (res_load),
        .res        (res),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data)
    );

    hbst_table #(
        .DEPTH  (NUM_BLOCKS),
        .ADDR_W (ADDR_BITS),
        .DATA_W (ENTRY_W)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign slot_free = !out_valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_reg <= res;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.update_distance = res_reg.update_distance;
    assign result.first_write     = res_reg.first_write;
    assign result.is_hot          = res_reg.is_hot;
    assign result.gc_done         = res_reg.gc_done;
    assign result.hot_set_size    = res_reg.hot_set_size;
    assign result.hot_write_count = res_reg.hot_write_count;
    assign result.set_size_sum    = res_reg.set_size_sum;
    assign result.hot_write_sum   = res_reg.hot_write_sum;
    assign result.collections     = res_reg.collections;

endmodule

// ===== design/hbst_checker.sv =====
// ----------------------------------------------------------------------------
// hbst_checker
// Port-level checks for the hot block separation tracker, bound to the top.
// ----------------------------------------------------------------------------
`include "hot_block_separation_tracker_macros.svh"

module hbst_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic [hbst_pkg::DIST_W-1:0]         update_distance,
    input  logic                                first_write,
    input  logic                                is_hot,
    input  logic                                gc_done,
    input  logic [hbst_pkg::SET_SIZE_W-1:0]     hot_set_size,
    input  logic [hbst_pkg::CNT_W-1:0]          hot_write_count
);

    // a result beat stays up until taken
    `HBST_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result beat dropped")

    // one item in flight: no accept on the cycle after an accept
    `HBST_ASSERT_NXT(a_one_inflight, in_valid && in_ready, !in_ready, "back-to-back accept")

    // a hot write is a rewrite at nonzero distance
    `HBST_ASSERT_IMP(a_hot_rewrite, out_valid && is_hot,
        !first_write && update_distance != '0, "hot on first write or zero distance")

    // a fresh collection leaves at most this write in the set and the count
    `HBST_ASSERT_IMP(a_gc_reset, out_valid && gc_done,
        hot_set_size <= 1 && hot_write_count <= 1, "collection did not clear set")

endmodule

bind hot_block_separation_tracker hbst_checker u_hbst_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (item.valid),
    .in_ready        (item.ready),
    .out_valid       (result.valid),
    .out_ready       (result.ready),
    .update_distance (result.update_distance),
    .first_write     (result.first_write),
    .is_hot          (result.is_hot),
    .gc_done         (result.gc_done),
    .hot_set_size    (result.hot_set_size),
    .hot_write_count (result.hot_write_count)
);

// ===== verif/tb_hot_block_separation_tracker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hot_block_separation_tracker
// Streams block writes into the tracker and scores every result beat against
// a cycle-free model of the stamp table, hot set and collection counters.
// Runs a directed set first, then random phases under several period and
// threshold settings, with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_hot_block_separation_tracker;
    import hbst_pkg::*;

    localparam int NUM_BLOCKS      = NUM_BLOCKS_DEF;
    localparam int STAMP_BITS      = STAMP_BITS_DEF;
    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 235;
    localparam int DRAIN_CYCLES    = 20;
    localparam int IDLE_PCT        = 7;

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 cfg_wr_en;
    cfg_index_t           cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    hbst_item_if   item_ch ();
    hbst_result_if result_ch ();

    hot_block_separation_tracker #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .STAMP_BITS (STAMP_BITS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (result_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // model state
    bit   [STAMP_BITS-1:0] block_stamp [int unsigned];
    bit   [TAG_W-1:0]      block_tag   [int unsigned];
    logic [STAMP_BITS-1:0] write_count;
    logic [CFG_W-1:0]      phase_count;
    logic [TAG_W-1:0]      epoch;
    logic [SET_SIZE_W-1:0] set_size;
    logic [CNT_W-1:0]      hot_count;
    logic [SUM_W-1:0]      size_total;
    logic [SUM_W-1:0]      hot_total;
    logic [CNT_W-1:0]      gc_count;
    logic [CFG_W-1:0]      gc_period_cfg;
    logic [CFG_W-1:0]      hot_thresh_cfg;

    logic [ADDR_IN_W-1:0]  pending_writes [$];
    hbst_result_t          due_results    [$];
    int                    writes_sent;
    int                    results_seen;
    int                    failures;

    logic [ADDR_IN_W-1:0]  hot_pool  [8];
    logic [ADDR_IN_W-1:0]  warm_pool [64];

    logic [CFG_W-1:0] phase_period [NUM_PHASES] = '{
        32'hFFFF_FFFF, 32'd50, 32'd0, 32'd1, 32'd7, 32'd13, 32'd200, 32'd5
    };
    logic [CFG_W-1:0] phase_thresh [NUM_PHASES] = '{
        32'hFFFF_FFFF, 32'd100, 32'd20, 32'd2, 32'd16, 32'd0, 32'd1000, 32'd1
    };

    function automatic hbst_result_t track_write(logic [ADDR_IN_W-1:0] addr_in);
        int unsigned           blk;
        logic [STAMP_BITS-1:0] prev;
        logic [DIST_W-1:0]     distance;
        logic [TAG_W-1:0]      mark;
        bit                    in_set;
        hbst_result_t          r;
        r     = '0;
        blk   = int'(addr_in) % NUM_BLOCKS;
        write_count = write_count + 1'b1;
        prev  = block_stamp.exists(blk) ? block_stamp[blk] : '0;
        // a zero stamp reads as never written
        if (prev == '0)
        begin
            distance = '0;
            r.first_write = 1'b1;
        end
        else
        begin
            distance = DIST_W'(STAMP_BITS'(write_count - prev));
        end
        block_stamp[blk] = write_count;

        phase_count = phase_count + 1'b1;
        if (phase_count >= gc_period_cfg)
        begin
            phase_count = '0;
            size_total  = size_total + SUM_W'(set_size);
            hot_total   = hot_total + SUM_W'(hot_count);
            gc_count    = gc_count + 1'b1;
            set_size    = '0;
            hot_count   = '0;
            epoch       = epoch + 1'b1;
            r.gc_done   = 1'b1;
        end

        mark   = epoch + 1'b1;
        in_set = block_tag.exists(blk) && (block_tag[blk] == mark);
        if (distance != '0 && distance < DIST_W'(hot_thresh_cfg))
        begin
            if (!in_set)
            begin
                block_tag[blk] = mark;
                set_size = set_size + 1'b1;
            end
            hot_count = hot_count + 1'b1;
            r.is_hot  = 1'b1;
        end
        else if (in_set)
        begin
            block_tag[blk] = '0;
            set_size = set_size - 1'b1;
        end

        r.update_distance = distance;
        r.hot_set_size    = set_size;
        r.hot_write_count = hot_count;
        r.set_size_sum    = size_total;
        r.hot_write_sum   = hot_total;
        r.collections     = gc_count;
        return r;
    endfunction

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            failures++;
        end
    endtask

    task automatic write_reg(cfg_index_t idx, logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_GC_PERIOD)
            gc_period_cfg = val;
        else
            hot_thresh_cfg = val;
    endtask

    // sender holds off until the block has answered everything
    task automatic wait_all_results();
        while (pending_writes.size() != 0 || item_ch.valid || due_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // write driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_ch.valid      <= 1'b0;
            item_ch.block_addr <= '0;
        end
        else
        begin
            if (item_ch.valid && item_ch.ready)
            begin
                due_results = {due_results, track_write(item_ch.block_addr)};
                writes_sent++;
            end
            if (!item_ch.valid || item_ch.ready)
            begin
                // no gaps across the calm stretch
                if (pending_writes.size() != 0 &&
                    ((writes_sent >= 700 && writes_sent < 1000) ||
                     $urandom_range(99) >= IDLE_PCT))
                begin
                    item_ch.valid      <= 1'b1;
                    item_ch.block_addr <= pending_writes.pop_front();
                end
                else
                begin
                    item_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        hbst_result_t want;
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                results_seen++;
                if (due_results.size() == 0)
                begin
                    $error("result beat with no write outstanding");
                    failures++;
                end
                else
                begin
                    want = due_results.pop_front();
                    check_field("update_distance", want.update_distance,
                                result_ch.update_distance);
                    check_field("first_write", want.first_write, result_ch.first_write);
                    check_field("is_hot", want.is_hot, result_ch.is_hot);
                    check_field("gc_done", want.gc_done, result_ch.gc_done);
                    check_field("hot_set_size", want.hot_set_size, result_ch.hot_set_size);
                    check_field("hot_write_count", want.hot_write_count,
                                result_ch.hot_write_count);
                    check_field("set_size_sum", want.set_size_sum, result_ch.set_size_sum);
                    check_field("hot_write_sum", want.hot_write_sum,
                                result_ch.hot_write_sum);
                    check_field("collections", want.collections, result_ch.collections);
                end
            end
            result_ch.ready <= (results_seen >= 700 && results_seen < 1000) ||
                               ($urandom_range(99) >= IDLE_PCT);
        end
    end

    initial
    begin
        #50ms;
        $display("hot_block_separation_tracker test failed");
        $finish;
    end

    initial
    begin
        int                   roll;
        logic [ADDR_IN_W-1:0] addr;
        cfg_wr_en          = 1'b0;
        cfg_index          = CFG_GC_PERIOD;
        cfg_data           = '0;
        write_count        = '0;
        phase_count        = '0;
        epoch              = '0;
        set_size           = '0;
        hot_count          = '0;
        size_total         = '0;
        hot_total          = '0;
        gc_count           = '0;
        gc_period_cfg      = GC_PERIOD_RST;
        hot_thresh_cfg     = HOT_THR_RST;
        writes_sent        = 0;
        results_seen       = 0;
        failures           = 0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: first writes, rewrites at distance 1..3, address extremes
        pending_writes = '{20'h00000, 20'hFFFFF, 20'h00000, 20'h00000, 20'hFFFFF,
                           20'h55555, 20'hAAAAA, 20'h55555, 20'h12345};
        wait_all_results();

        // period lowered below the running phase: collection on the next write
        write_reg(CFG_GC_PERIOD, 32'd3);
        write_reg(CFG_HOT_THRESHOLD, 32'd4);
        pending_writes = '{20'h00000, 20'h00000, 20'h00000, 20'h00001, 20'h00001,
                           20'hFFFFF, 20'hFFFFF, 20'h00000, 20'h00001, 20'h80000,
                           20'h80000, 20'h7FFFF, 20'h80000};
        wait_all_results();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_reg(CFG_GC_PERIOD, phase_period[p]);
            write_reg(CFG_HOT_THRESHOLD, phase_thresh[p]);
            foreach (hot_pool[i])
                hot_pool[i] = ADDR_IN_W'($urandom);
            foreach (warm_pool[i])
                warm_pool[i] = ADDR_IN_W'($urandom);
            // short distances from a tight pool, longer from a wider one, some fresh blocks
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                roll = $urandom_range(99);
                if (roll < 60)
                    addr = hot_pool[$urandom_range(7)];
                else if (roll < 85)
                    addr = warm_pool[$urandom_range(63)];
                else
                    addr = ADDR_IN_W'($urandom);
                pending_writes = {pending_writes, addr};
            end
            wait_all_results();
        end

        if (failures == 0)
            $display("hot_block_separation_tracker test passed");
        else
            $display("hot_block_separation_tracker test failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/hbst_pkg.sv
design/hbst_if.sv
design/hbst_table.sv
design/hbst_core.sv
design/hot_block_separation_tracker.sv
design/hbst_checker.sv
verif/tb_hot_block_separation_tracker.sv
